/* src/smf_pkg.sv */
// smf_pkg: shared types for the streaming median finder
// holds the control struct passed from the top level to every sorting cell
// no dependencies
`default_nettype none

package smf_pkg;

	// per-cycle commands broadcast to the cell chain
	typedef struct packed {
		logic insert;   // place the broadcast key into the sorted row
		logic drain;    // move every value one cell toward cell zero
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* src/smf_cell.sv */
// smf_cell: one slot of the sorted row of the median finder
// depends on smf_pkg for the control struct
`default_nettype none

module smf_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int IDX        = 0
) (
	input  wire                          clk,
	input  smf_pkg::cell_ctrl_t          ctrl,
	input  wire logic [DATA_WIDTH-1:0]   key,
	input  wire logic [CNT_W-1:0]        count,
	input  wire logic [DATA_WIDTH-1:0]   prev_val,
	input  wire logic                    prev_gt,
	input  wire logic [DATA_WIDTH-1:0]   next_val,
	output logic      [DATA_WIDTH-1:0]   val,
	output logic                         gt
);
	import smf_pkg::*;

	localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

	logic [DATA_WIDTH-1:0] val_q;

	// this slot moves up: it holds a value greater than the key, or it is the first free slot
	assign gt  = ((POS < count) && ($signed(val_q) > $signed(key))) || (POS == count);
	assign val = val_q;

	// slot update: on insert take the lower neighbor if it moves up, else the key; take the upper one on drain
	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			val_q <= next_val;
		end else if (ctrl.insert && gt) begin
			val_q <= prev_gt ? prev_val : key;
		end
	end

endmodule

`default_nettype wire

/* src/smf_mean.sv */
// smf_mean: median arithmetic, one registered wide sum then a halving with truncation
// standalone, no package use
`default_nettype none

module smf_mean #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                          clk,
	input  wire logic                    load,
	input  wire logic                    odd,
	input  wire logic [DATA_WIDTH-1:0]   lo_val,
	input  wire logic [DATA_WIDTH-1:0]   hi_val,
	output logic      [DATA_WIDTH-1:0]   median
);
	logic signed [DATA_WIDTH:0] sum_q;
	logic signed [DATA_WIDTH:0] half;

	// odd set keeps the middle value, even set sums the two middle values one bit wider
	always_ff @(posedge clk) begin
		if (load) begin
			if (odd) begin
				sum_q <= {lo_val[DATA_WIDTH-1], lo_val};
			end else begin
				sum_q <= $signed({lo_val[DATA_WIDTH-1], lo_val})
					+ $signed({hi_val[DATA_WIDTH-1], hi_val});
			end
		end
	end

	// floor halving, bumped by one for negative odd sums to truncate toward zero
	assign half = (sum_q >>> 1) + $signed({{DATA_WIDTH{1'b0}}, sum_q[DATA_WIDTH] & sum_q[0]});

	logic odd_q;
	always_ff @(posedge clk) begin
		if (load) begin
			odd_q <= odd;
		end
	end

	assign median = odd_q ? sum_q[DATA_WIDTH-1:0] : half[DATA_WIDTH-1:0];

endmodule

`default_nettype wire

/* src/streaming_median_finder_top.sv */
// streaming_median_finder_top: median of a framed set of signed samples
// depends on smf_pkg, smf_cell and smf_mean
`default_nettype none

// Samples arrive one per beat on the slave stream and are kept in ascending order in a
// row of MAX_ITEMS cells; each beat inserts its sample as it is taken, so a set streams in
// at one sample per clock. The beat with tlast closes the set: the row is then shifted
// toward cell zero until the middle values reach the two front cells (ST_SHIFT), the
// sum is formed (ST_SUM) and the result register loads (ST_LOAD); the slave side is held
// off through these states after a last beat (plus any wait for a result still pending
// on the master side). The result beat carries the median (mean of the two
// middle values truncated toward zero for an even count), the number of values kept,
// and in tuser a flag that values past MAX_ITEMS were dropped. Equal samples keep their
// arrival order.
module streaming_median_finder_top #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32,
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1),
	localparam int S_W    = ((DATA_WIDTH + 7) / 8) * 8,
	localparam int M_W    = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire  [S_W-1:0]     s_tdata,    // sample
	input  wire                s_tlast,    // final_item
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [M_W-1:0]     m_tdata,    // median, set_size, zero pad
	output logic               m_tuser     // dropped
);
	import smf_pkg::*;

	typedef enum logic [1:0] {ST_TAKE, ST_SHIFT, ST_SUM, ST_LOAD} state_t;

	localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ITEMS);

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic                   drop_q;
	logic [CNT_W-1:0]       size_q;
	logic                   res_drop_q;
	logic [CNT_W-1:0]       shift_q;

	logic                   beat;
	logic                   room;
	logic                   out_load;
	logic [CNT_W-1:0]       new_count;
	logic [CNT_W-1:0]       shifts;
	cell_ctrl_t             ctrl;
	logic [DATA_WIDTH-1:0]  key;
	logic [DATA_WIDTH-1:0]  cell_val [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]   cell_gt;
	logic [DATA_WIDTH-1:0]  median;

	assign s_tready  = (state_q == ST_TAKE);
	assign beat      = s_tvalid && s_tready;
	assign key       = s_tdata[DATA_WIDTH-1:0];
	assign room      = (count_q != FULL);
	assign new_count = count_q + CNT_W'(room);
	assign shifts    = (new_count - CNT_W'(1)) >> 1;
	assign out_load  = (state_q == ST_LOAD) && (!m_tvalid || m_tready);

	assign ctrl.insert = beat && room;
	assign ctrl.drain  = (state_q == ST_SHIFT);

	// sorting row
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_v;
		logic                  prev_g;
		logic [DATA_WIDTH-1:0] next_v;
		if (i == 0) begin : g_first
			assign prev_v = key;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_v = cell_val[i-1];
			assign prev_g = cell_gt[i-1];
		end
		if (i == MAX_ITEMS - 1) begin : g_last
			assign next_v = cell_val[i];
		end else begin : g_inner
			assign next_v = cell_val[i+1];
		end
		smf_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.key      (key),
			.count    (count_q),
			.prev_val (prev_v),
			.prev_gt  (prev_g),
			.next_val (next_v),
			.val      (cell_val[i]),
			.gt       (cell_gt[i])
		);
	end

	// median arithmetic over the two front cells
	smf_mean #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_mean (
		.clk    (clk),
		.load   (state_q == ST_SUM),
		.odd    (size_q[0]),
		.lo_val (cell_val[0]),
		.hi_val (cell_val[1 % MAX_ITEMS]),
		.median (median)
	);

	// sequencer, set bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_TAKE;
			count_q    <= '0;
			drop_q     <= 1'b0;
			size_q     <= '0;
			res_drop_q <= 1'b0;
			shift_q    <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= 1'b0;
		end else begin
			// result register: load a new beat or retire the one taken
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= M_W'({size_q, median});
				m_tuser  <= res_drop_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_TAKE: begin
					if (beat) begin
						if (s_tlast) begin
							size_q     <= new_count;
							res_drop_q <= drop_q || !room;
							shift_q    <= shifts;
							count_q    <= '0;
							drop_q     <= 1'b0;
							state_q    <= (shifts == '0) ? ST_SUM : ST_SHIFT;
						end else begin
							count_q <= new_count;
							drop_q  <= drop_q || !room;
						end
					end
				end
				ST_SHIFT: begin
					shift_q <= shift_q - CNT_W'(1);
					if (shift_q == CNT_W'(1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_load) begin
						state_q <= ST_TAKE;
					end
				end
				default: begin
					state_q <= ST_TAKE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/smf_checker.sv */
// smf_checker: port-level checks for the streaming median finder, bound to the top level
// depends on streaming_median_finder_top port and parameter names only
`default_nettype none

module smf_checker #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32,
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1),
	localparam int S_W    = ((DATA_WIDTH + 7) / 8) * 8,
	localparam int M_W    = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
	input wire              clk,
	input wire              arst_n,
	input wire              s_tvalid,
	input wire              s_tready,
	input wire  [S_W-1:0]   s_tdata,
	input wire              s_tlast,
	input wire              m_tvalid,
	input wire              m_tready,
	input wire  [M_W-1:0]   m_tdata,
	input wire              m_tuser
);
	logic [CNT_W-1:0] size;
	assign size = m_tdata[DATA_WIDTH +: CNT_W];

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// a last beat closes the set and stops intake for readout
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("intake open right after last beat");

	// inside a set, intake stays ready after each beat
	a_mid_open: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast |=> s_tready)
		else $error("intake stalled inside a set");

	// a result always covers at least one value, and a drop means a full set
	a_size_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (size != '0) && (!m_tuser || (size == CNT_W'(MAX_ITEMS))))
		else $error("bad set size on result beat");

	logic unused;
	assign unused = ^s_tdata;

endmodule

bind streaming_median_finder_top smf_checker #(
	.MAX_ITEMS  (MAX_ITEMS),
	.DATA_WIDTH (DATA_WIDTH)
) u_smf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
